// ===== src/delimited_receive_buffer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Delimited receive buffer unit: assertion macros
// Shared property macros for the port checker.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_RECEIVE_BUFFER_UNIT_DEFINES_SVH
`define DELIMITED_RECEIVE_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define DRBU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define DRBU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/drbu_pkg.sv =====
// ----------------------------------------------------------------------------
// drbu_pkg
// Types and constants of the delimited receive buffer unit.
// ----------------------------------------------------------------------------
package drbu_pkg;

  localparam int unsigned BufDepth = 64;
  localparam int unsigned AddrW    = $clog2(BufDepth);
  localparam int unsigned CntW     = AddrW + 1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    KIND_RECEIVE   = 3'd0,
    KIND_READ_LINE = 3'd1,
    KIND_READ_UNTL = 3'd2,
    KIND_READ_CNT  = 3'd3,
    KIND_READ_ALL  = 3'd4,
    KIND_CLEAR     = 3'd5,
    KIND_POP_LAST  = 3'd6,
    KIND_PEEK_LAST = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_PEEK,
    ST_EMIT,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] rx_byte;
    logic [7:0] delimiter;
    logic [6:0] max_count;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic [6:0] moved_count;
    logic [5:0] fill_now;
    logic       overflow_mark;
    logic       line_ready;
    logic       delimiter_ready;
  } res_t;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [7:0]       wr_data;
  } mem_req_t;

endpackage

// ===== src/delimited_receive_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// delimited_receive_buffer_unit
// Serial receive line buffer with line, delimiter, count and bulk reads, plus clear, pop and peek.
// ----------------------------------------------------------------------------
// Output: every command other than a read that removes bytes yields a single word;
//   a read that removes n bytes emits n words on consecutive cycles. A new command
//   is taken only once the last one is through, including its shift; the one read
//   port is shared by scan, emit and shift.
// Reset: asynchronous; clears control, fill, overflow mark and written bits.
module delimited_receive_buffer_unit import drbu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic result_valid_o,
  output res_t result_o
);

  state_e            state_q, state_d;
  in_t               item_q, item_d;
  logic [AddrW-1:0]  fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AddrW-1:0]  n_q, n_d;
  logic              lr_q, lr_d;
  logic              dr_q, dr_d;
  // scan results over the filled part before the operation
  logic              crlf_q, crlf_d;
  logic [AddrW-1:0]  first_end_q, first_end_d;
  logic [AddrW-1:0]  last_start_q, last_start_d;
  logic              dl_q, dl_d;
  logic [AddrW-1:0]  first_dl_q, first_dl_d;
  logic [AddrW-1:0]  last_dl_q, last_dl_d;
  logic [7:0]        prev_q, prev_d;
  // read pipeline
  logic              rd_vld_q;
  logic [AddrW-1:0]  rd_addr_q;
  logic [7:0]        rd_data;
  mem_req_t          req;
  res_t              res_q, res_d;
  logic              res_vld_q, res_vld_d;

  logic [AddrW-1:0]  read_len;
  logic [CntW-1:0]   shift_src;
  logic              wrap;

  assign shift_src = cnt_q + {1'b0, n_q};
  assign wrap      = (fill_q == AddrW'(BufDepth - 1));

  // Number of bytes a read removes, from the pre-operation scan.
  always_comb begin
    unique case (item_q.kind)
      KIND_READ_LINE: read_len = crlf_q ? first_end_q + AddrW'(1) : '0;
      KIND_READ_UNTL: read_len = dl_q ? first_dl_q + AddrW'(1) : '0;
      KIND_READ_CNT:  read_len = (item_q.max_count < {1'b0, fill_q}) ?
                                 item_q.max_count[AddrW-1:0] : fill_q;
      KIND_READ_ALL:  read_len = fill_q;
      default:        read_len = '0;
    endcase
  end

  drbu_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      cnt_q     <= '0;
      crlf_q    <= 1'b0;
      dl_q      <= 1'b0;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      ovf_q     <= ovf_d;
      cnt_q     <= cnt_d;
      crlf_q    <= crlf_d;
      dl_q      <= dl_d;
      rd_vld_q  <= req.rd_en;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    n_q          <= n_d;
    lr_q         <= lr_d;
    dr_q         <= dr_d;
    first_end_q  <= first_end_d;
    last_start_q <= last_start_d;
    first_dl_q   <= first_dl_d;
    last_dl_q    <= last_dl_d;
    prev_q       <= prev_d;
    rd_addr_q    <= req.rd_addr;
    res_q        <= res_d;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    fill_d       = fill_q;
    ovf_d        = ovf_q;
    cnt_d        = cnt_q;
    n_d          = n_q;
    lr_d         = lr_q;
    dr_d         = dr_q;
    crlf_d       = crlf_q;
    first_end_d  = first_end_q;
    last_start_d = last_start_q;
    dl_d         = dl_q;
    first_dl_d   = first_dl_q;
    last_dl_d    = last_dl_q;
    prev_d       = prev_q;
    req          = '0;
    res_d        = res_q;
    res_vld_d    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d  = in_i;
          crlf_d  = 1'b0;
          dl_d    = 1'b0;
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Walk the filled part once, noting first and last CR LF and delimiter.
        if (cnt_q < {1'b0, fill_q}) begin
          req.rd_en   = 1'b1;
          req.rd_addr = cnt_q[AddrW-1:0];
          cnt_d       = cnt_q + CntW'(1);
        end
        if (rd_vld_q) begin
          if (rd_addr_q != '0 && prev_q == CH_CR && rd_data == CH_LF) begin
            crlf_d       = 1'b1;
            last_start_d = rd_addr_q - AddrW'(1);
            if (!crlf_q) begin
              first_end_d = rd_addr_q;
            end
          end
          if (rd_data == item_q.delimiter) begin
            dl_d      = 1'b1;
            last_dl_d = rd_addr_q;
            if (!dl_q) begin
              first_dl_d = rd_addr_q;
            end
          end
          prev_d = rd_data;
        end
        if (cnt_q == {1'b0, fill_q} && !rd_vld_q) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_d.data_byte       = 8'h00;
        res_d.byte_valid      = 1'b0;
        res_d.last            = 1'b1;
        res_d.moved_count     = '0;
        res_d.fill_now        = fill_q;
        res_d.overflow_mark   = ovf_q;
        res_d.line_ready      = crlf_q;
        res_d.delimiter_ready = dl_q;
        res_vld_d             = 1'b1;
        state_d               = ST_IDLE;
        unique case (item_q.kind)
          KIND_RECEIVE: begin
            // Append; wrap to empty and set the sticky mark when full.
            req.wr_en             = 1'b1;
            req.wr_addr           = fill_q;
            req.wr_data           = item_q.rx_byte;
            fill_d                = wrap ? '0 : fill_q + AddrW'(1);
            ovf_d                 = ovf_q | wrap;
            res_d.fill_now        = fill_d;
            res_d.overflow_mark   = ovf_d;
            res_d.line_ready      = !wrap && (crlf_q || (fill_q != '0 && prev_q == CH_CR
                                    && item_q.rx_byte == CH_LF));
            res_d.delimiter_ready = !wrap && (dl_q || item_q.rx_byte == item_q.delimiter);
          end
          KIND_CLEAR: begin
            fill_d                = '0;
            res_d.moved_count     = {1'b0, fill_q};
            res_d.fill_now        = '0;
            res_d.line_ready      = 1'b0;
            res_d.delimiter_ready = 1'b0;
          end
          KIND_POP_LAST: begin
            if (fill_q != '0) begin
              // Newest byte is the last one scanned; drop it from the tail.
              fill_d                = fill_q - AddrW'(1);
              res_d.data_byte       = prev_q;
              res_d.byte_valid      = 1'b1;
              res_d.moved_count     = 7'd1;
              res_d.fill_now        = fill_d;
              res_d.line_ready      = crlf_q && (first_end_q < fill_d);
              res_d.delimiter_ready = dl_q && (first_dl_q < fill_d);
            end else begin
              req.wr_en   = 1'b1;
              req.wr_addr = '0;
              req.wr_data = 8'h00;
            end
          end
          KIND_PEEK_LAST: begin
            if (fill_q != '0) begin
              res_d.data_byte  = prev_q;
              res_d.byte_valid = 1'b1;
            end else begin
              // Empty: fetch the top entry of the store.
              req.rd_en   = 1'b1;
              req.rd_addr = AddrW'(BufDepth - 1);
              res_vld_d   = 1'b0;
              state_d     = ST_PEEK;
            end
          end
          default: begin
            if (read_len != '0) begin
              // Status after removal: any occurrence lying past the cut survives.
              n_d       = read_len;
              fill_d    = fill_q - read_len;
              lr_d      = crlf_q && (last_start_q >= read_len);
              dr_d      = dl_q && (last_dl_q >= read_len);
              cnt_d     = '0;
              res_vld_d = 1'b0;
              state_d   = ST_EMIT;
            end
          end
        endcase
      end

      ST_PEEK: begin
        if (rd_vld_q) begin
          res_d.data_byte       = rd_data;
          res_d.byte_valid      = 1'b1;
          res_d.last            = 1'b1;
          res_d.moved_count     = '0;
          res_d.fill_now        = fill_q;
          res_d.overflow_mark   = ovf_q;
          res_d.line_ready      = crlf_q;
          res_d.delimiter_ready = dl_q;
          res_vld_d             = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      ST_EMIT: begin
        // Stream the front n bytes out, one word per cycle.
        if (cnt_q < {1'b0, n_q}) begin
          req.rd_en   = 1'b1;
          req.rd_addr = cnt_q[AddrW-1:0];
          cnt_d       = cnt_q + CntW'(1);
        end
        if (rd_vld_q) begin
          res_d.data_byte       = rd_data;
          res_d.byte_valid      = 1'b1;
          res_d.last            = (rd_addr_q == n_q - AddrW'(1));
          res_d.moved_count     = res_d.last ? {1'b0, n_q} : '0;
          res_d.fill_now        = fill_q;
          res_d.overflow_mark   = ovf_q;
          res_d.line_ready      = lr_q;
          res_d.delimiter_ready = dr_q;
          res_vld_d             = 1'b1;
          if (res_d.last) begin
            cnt_d   = '0;
            state_d = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        // Move every entry down by n; the top n entries keep stale values.
        if (shift_src < CntW'(BufDepth)) begin
          req.rd_en   = 1'b1;
          req.rd_addr = shift_src[AddrW-1:0];
          cnt_d       = cnt_q + CntW'(1);
        end
        if (rd_vld_q) begin
          req.wr_en   = 1'b1;
          req.wr_addr = rd_addr_q - n_q;
          req.wr_data = rd_data;
        end
        if (shift_src >= CntW'(BufDepth) && !rd_vld_q) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

// ===== src/drbu_ram.sv =====
// ----------------------------------------------------------------------------
// drbu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drbu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/drbu_store.sv =====
// ----------------------------------------------------------------------------
// drbu_store
// Byte store: RAM plus per-entry written bits so unwritten entries read zero.
// ----------------------------------------------------------------------------
module drbu_store import drbu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_req_t   req_i,
  output logic [7:0] rd_data_o
);

  logic [BufDepth-1:0] written_q;
  logic                rd_written_q;
  logic [7:0]          ram_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_written_q <= written_q[req_i.rd_addr];
      end
    end
  end

  drbu_ram #(
    .Width(8),
    .Depth(BufDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.wr_en),
    .waddr_i(req_i.wr_addr),
    .wdata_i(req_i.wr_data),
    .re_i   (req_i.rd_en),
    .raddr_i(req_i.rd_addr),
    .rdata_o(ram_data)
  );

  // Never-written entries read as zero.
  assign rd_data_o = rd_written_q ? ram_data : 8'h00;

endmodule

// ===== src/drbu_checker.sv =====
// ----------------------------------------------------------------------------
// drbu_checker
// Port-level checks of the delimited receive buffer unit.
// ----------------------------------------------------------------------------
`include "delimited_receive_buffer_unit_defines.svh"

module drbu_checker import drbu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  in_i,
  input logic result_valid_o,
  input res_t result_o
);

  `DRBU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `DRBU_ASSERT_NEXT(a_burst_gapless, result_valid_o && !result_o.last, result_valid_o,
    "gap inside a multi-word read")
  `DRBU_ASSERT_NOW(a_empty_is_last, result_valid_o && !result_o.byte_valid, result_o.last,
    "word without a byte is not the last")
  `DRBU_ASSERT_NOW(a_moved_on_last, result_valid_o && !result_o.last,
    result_o.moved_count == 7'd0, "moved count set before the last word")

endmodule

bind delimited_receive_buffer_unit drbu_checker u_drbu_checker (.*);

// ===== tb/tb_delimited_receive_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_delimited_receive_buffer_unit
// Drives receive, read, clear, pop and peek commands into the line buffer with random
// gaps and checks every output word against a behavioural model of the byte store.
// ----------------------------------------------------------------------------
module tb_delimited_receive_buffer_unit;
  import drbu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  in_i;
  logic result_valid_o;
  res_t result_o;

  delimited_receive_buffer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Model state: byte store, fill level, sticky wrap mark.
  logic [7:0] model_store [BufDepth];
  int unsigned model_fill;
  logic        model_ovf;
  res_t        pending_words [$];
  int unsigned error_count;

  // Directed rows; use_exp marks rows whose last predicted word is typed in.
  typedef struct {
    in_t  cmd;
    bit   use_exp;
    res_t exp;
  } row_t;

  function automatic int unsigned line_len();
    for (int unsigned i = 1; i < model_fill; i++) begin
      if (model_store[i-1] == CH_CR && model_store[i] == CH_LF) return i + 1;
    end
    return 0;
  endfunction

  function automatic int unsigned delim_len(logic [7:0] d);
    for (int unsigned i = 0; i < model_fill; i++) begin
      if (model_store[i] == d) return i + 1;
    end
    return 0;
  endfunction

  function automatic res_t status_word(logic [7:0] b, logic v, logic lst,
                                       int unsigned moved, logic [7:0] d);
    res_t r;
    r.data_byte       = b;
    r.byte_valid      = v;
    r.last            = lst;
    r.moved_count     = lst ? moved[6:0] : 7'd0;
    r.fill_now        = model_fill[5:0];
    r.overflow_mark   = model_ovf;
    r.line_ready      = line_len() != 0;
    r.delimiter_ready = delim_len(d) != 0;
    return r;
  endfunction

  // Advance the model by one command and queue the words it causes.
  task automatic predict_words(in_t c);
    int unsigned n;
    logic [7:0]  taken [BufDepth];
    logic [7:0]  b;
    logic        v;
    int unsigned moved;
    n = 0;
    b = 8'd0;
    v = 1'b0;
    moved = 0;
    case (c.kind)
      KIND_RECEIVE: begin
        model_store[model_fill] = c.rx_byte;
        model_fill++;
        if (model_fill >= BufDepth) begin
          model_fill = 0;
          model_ovf  = 1'b1;
        end
      end
      KIND_READ_LINE: n = line_len();
      KIND_READ_UNTL: n = delim_len(c.delimiter);
      KIND_READ_CNT:  n = (c.max_count < model_fill) ? c.max_count : model_fill;
      KIND_READ_ALL:  n = model_fill;
      KIND_CLEAR: begin
        moved = model_fill;
        model_fill = 0;
      end
      KIND_POP_LAST: begin
        if (model_fill != 0) begin
          model_fill--;
          b = model_store[model_fill];
          v = 1'b1;
          moved = 1;
        end else begin
          model_store[0] = 8'd0;
        end
      end
      default: begin
        b = (model_fill == 0) ? model_store[BufDepth-1] : model_store[model_fill-1];
        v = 1'b1;
      end
    endcase
    if (n > 0) begin
      for (int unsigned i = 0; i < n; i++) taken[i] = model_store[i];
      // Shift left; stale tail entries stay.
      for (int unsigned i = 0; i + n < BufDepth; i++) model_store[i] = model_store[i+n];
      model_fill -= n;
      for (int unsigned i = 0; i < n; i++) begin
        pending_words.push_back(status_word(taken[i], 1'b1, i + 1 == n, n, c.delimiter));
      end
    end else begin
      pending_words.push_back(status_word(b, v, 1'b1, moved, c.delimiter));
    end
  endtask

  // Check each output word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $realtime, result_o);
        error_count++;
      end else if (pending_words[0] !== result_o) begin
        $display("%0t: mismatch, expected %p, actual %p", $realtime, pending_words[0],
                 result_o);
        error_count++;
        void'(pending_words.pop_front());
      end else begin
        void'(pending_words.pop_front());
      end
    end
  end

  // Hold start high until the unit takes the word; a nonzero gap that follows drops it.
  task automatic send_cmd(in_t c, bit use_exp, res_t exp);
    start <= 1'b1;
    in_i  <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // Accepted at this edge.
    if (use_exp) begin
      predict_words(c);
      if (pending_words[pending_words.size()-1] !== exp) begin
        $display("%0t: table row mismatch, expected %p, model %p", $realtime, exp,
                 pending_words[pending_words.size()-1]);
        error_count++;
      end
    end else begin
      predict_words(c);
    end
  endtask

  task automatic idle_gap();
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) start <= 1'b0;
    repeat (g) @(posedge clk_i);
  endtask

  function automatic in_t make_cmd(kind_e k, logic [7:0] rx, logic [7:0] d,
                                   logic [6:0] mc);
    in_t c;
    c.kind = k;
    c.rx_byte = rx;
    c.delimiter = d;
    c.max_count = mc;
    return c;
  endfunction

  function automatic res_t make_res(logic [7:0] b, logic v, logic [6:0] m,
                                    logic [5:0] f, logic o, logic lr, logic dr);
    res_t r;
    r.data_byte = b;
    r.byte_valid = v;
    r.last = 1'b1;
    r.moved_count = m;
    r.fill_now = f;
    r.overflow_mark = o;
    r.line_ready = lr;
    r.delimiter_ready = dr;
    return r;
  endfunction

  // Random command, mostly line traffic with random content.
  function automatic in_t rand_cmd();
    int unsigned sel;
    logic [7:0]  rx;
    sel = $urandom_range(0, 99);
    rx = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) rx = ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
    if (sel < 60) return make_cmd(KIND_RECEIVE, rx, 8'($urandom_range(0, 255)),
                                  7'($urandom_range(0, 127)));
    return make_cmd(kind_e'($urandom_range(1, 7)), rx,
                    ($urandom_range(0, 1) != 0) ? CH_LF : 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 8)));
  endfunction

  row_t rows [$];

  initial begin
    error_count = 0;
    model_fill = 0;
    model_ovf = 1'b0;
    for (int i = 0; i < BufDepth; i++) model_store[i] = 8'd0;
    start  <= 1'b0;
    in_i   <= '0;
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-store cases, a line, delimiter, counts, pop, peek, clear.
    rows.push_back('{make_cmd(KIND_READ_LINE, 8'd0, 8'd0, 7'd0), 1,
                     make_res(8'd0, 1'b0, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0)});
    rows.push_back('{make_cmd(KIND_READ_ALL, 8'd0, 8'hFF, 7'd0), 1,
                     make_res(8'd0, 1'b0, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0)});
    rows.push_back('{make_cmd(KIND_POP_LAST, 8'd0, 8'd0, 7'd0), 1,
                     make_res(8'd0, 1'b0, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0)});
    rows.push_back('{make_cmd(KIND_PEEK_LAST, 8'd0, 8'd0, 7'd0), 1,
                     make_res(8'd0, 1'b1, 7'd0, 6'd0, 1'b0, 1'b0, 1'b0)});
    rows.push_back('{make_cmd(KIND_RECEIVE, 8'hFF, 8'h00, 7'd0), 1,
                     make_res(8'd0, 1'b0, 7'd0, 6'd1, 1'b0, 1'b0, 1'b0)});
    rows.push_back('{make_cmd(KIND_RECEIVE, CH_CR, 8'hFF, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_READ_LINE, 8'd0, 8'd0, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_RECEIVE, CH_LF, 8'd0, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_RECEIVE, 8'h00, 8'd0, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_READ_LINE, 8'd0, 8'd0, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_READ_UNTL, 8'd0, 8'h55, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_READ_UNTL, 8'd0, 8'h00, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_RECEIVE, 8'h55, 8'h55, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_RECEIVE, 8'hAA, 8'h55, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_READ_CNT, 8'd0, 8'd0, 7'd1), 0, '0});
    rows.push_back('{make_cmd(KIND_READ_CNT, 8'd0, 8'd0, 7'd127), 0, '0});
    rows.push_back('{make_cmd(KIND_RECEIVE, 8'h3C, 8'd0, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_READ_CNT, 8'd0, 8'd0, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_PEEK_LAST, 8'd0, 8'd0, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_POP_LAST, 8'd0, 8'd0, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_RECEIVE, 8'hC3, 8'd0, 7'd64), 0, '0});
    rows.push_back('{make_cmd(KIND_CLEAR, 8'd0, 8'd0, 7'd0), 0, '0});
    rows.push_back('{make_cmd(KIND_PEEK_LAST, 8'd0, 8'hC3, 7'd0), 0, '0});
    foreach (rows[i]) begin
      send_cmd(rows[i].cmd, rows[i].use_exp, rows[i].exp);
      idle_gap();
    end

    // Fill to the wrap so the overflow mark and peek-when-empty are seen.
    for (int i = 0; i < BufDepth; i++) begin
      send_cmd(make_cmd(KIND_RECEIVE, 8'($urandom_range(0, 255)), 8'd0, 7'd0), 0, '0);
    end
    send_cmd(make_cmd(KIND_PEEK_LAST, 8'd0, 8'd0, 7'd0), 0, '0);
    start <= 1'b0;

    // Hold off until the unit has drained everything once.
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    for (int i = 0; i < 110; i++) begin
      send_cmd(rand_cmd(), 0, '0);
      idle_gap();
    end
    start <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/drbu_pkg.sv
src/drbu_ram.sv
src/drbu_store.sv
src/delimited_receive_buffer_unit.sv
src/drbu_checker.sv
tb/tb_delimited_receive_buffer_unit.sv
